FILE: hw/rtl/rfeu_pkg.sv
// shared types, field positions and operation codes of the register file execute unit
package rfeu_pkg;

	localparam int unsigned WORD_W          = 32;
	localparam int unsigned FUNC_W          = 3;
	localparam int unsigned REG_IDX_W       = 3;
	localparam int unsigned NUM_REGS        = 8;
	localparam int unsigned IMM_W           = 25;
	localparam int unsigned REG_A_LSB       = 6;
	localparam int unsigned REG_B_LSB       = 3;
	localparam int unsigned REG_C_LSB       = 0;
	localparam int unsigned IMM_REG_LSB     = 25;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [FUNC_W-1:0] OP_CMOV  = 3'd0;
	localparam logic [FUNC_W-1:0] OP_ADD   = 3'd1;
	localparam logic [FUNC_W-1:0] OP_MULT  = 3'd2;
	localparam logic [FUNC_W-1:0] OP_DIV   = 3'd3;
	localparam logic [FUNC_W-1:0] OP_NAND  = 3'd4;
	localparam logic [FUNC_W-1:0] OP_LOADV = 3'd5;

	// decoded request as it sits in the queue
	typedef struct packed {
		logic [FUNC_W-1:0]    func;
		logic [REG_IDX_W-1:0] reg_a;
		logic [REG_IDX_W-1:0] reg_b;
		logic [REG_IDX_W-1:0] reg_c;
		logic [IMM_W-1:0]     imm;
	} item_t;

	// result word, lowest field in the lowest bits, padded to whole bytes
	typedef struct packed {
		logic [2:0]           pad;
		logic                 div_by_zero;
		logic [WORD_W-1:0]    dest_value;
		logic [REG_IDX_W-1:0] dest_reg;
		logic                 wrote;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [WORD_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: hw/rtl/rfeu_front.sv
// front end: accepts requests, decodes register fields and queues them
module rfeu_front #(
	parameter int unsigned QUEUE_DEPTH = rfeu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rfeu_pkg::WORD_W-1:0]        s_tdata,   // instr_word
	input  logic [rfeu_pkg::FUNC_W-1:0]        s_tuser,   // func
	output logic                               item_valid,
	input  logic                               item_ready,
	output rfeu_pkg::item_t                    item
);
	import rfeu_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	item_t            fifo_q [QUEUE_DEPTH];
	item_t            dec;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	// load immediate takes its destination from bits 27:25, just above the immediate
	always_comb begin
		dec.func  = s_tuser;
		dec.reg_a = (s_tuser == OP_LOADV) ? s_tdata[IMM_REG_LSB +: REG_IDX_W]
		                                  : s_tdata[REG_A_LSB +: REG_IDX_W];
		dec.reg_b = s_tdata[REG_B_LSB +: REG_IDX_W];
		dec.reg_c = s_tdata[REG_C_LSB +: REG_IDX_W];
		dec.imm   = s_tdata[IMM_W-1:0];
	end

	assign s_tready   = (cnt_q != FULL_CNT);
	assign item_valid = (cnt_q != '0);
	assign item       = fifo_q[rd_ptr_q];
	assign push       = s_tvalid && s_tready;
	assign pop        = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/rfeu_divider.sv
// restoring unsigned divider, one quotient bit per cycle
module rfeu_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  rfeu_pkg::div_req_t req,
	output rfeu_pkg::div_rsp_t rsp
);
	import rfeu_pkg::*;

	localparam int unsigned STEP_W = $clog2(WORD_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   diff;

	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			// one-cycle pulse after the last quotient bit
			done_q <= !req.start && busy_q && (cnt_q == LAST_STEP);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= req.dividend;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				// keep the trial difference when it did not borrow
				rem_q <= diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], ~diff[WORD_W]};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

FILE: hw/rtl/rfeu_back.sv
// back end: register file, operation sequencer and output register
module rfeu_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  rfeu_pkg::item_t                  item,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rfeu_pkg::RESULT_W-1:0]    m_tdata,
	output rfeu_pkg::div_req_t               div_req,
	input  rfeu_pkg::div_rsp_t               div_rsp
);
	import rfeu_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t               state_q;
	item_t                cur_q;
	logic                 wr_q;
	logic                 dz_q;
	logic [WORD_W-1:0]    nv_q;
	result_t              out_q;
	logic                 out_valid_q;

	logic [WORD_W-1:0]    mem [NUM_REGS];
	logic [NUM_REGS-1:0]  vld_q;
	logic [WORD_W-1:0]    rd0_q;
	logic [WORD_W-1:0]    rd1_q;
	logic [REG_IDX_W-1:0] rd0_addr;
	logic                 rd0_en;
	logic                 rd1_en;
	logic                 mem_we;

	logic                 ex_wr;
	logic                 ex_dz;
	logic                 ex_div;
	logic [WORD_W-1:0]    ex_nv;
	logic [WORD_W-1:0]    prod;
	logic                 out_free;
	result_t              fin;

	// port 0 reads B on issue, then A while the operation runs
	assign rd0_addr = (state_q == ST_IDLE) ? item.reg_b : cur_q.reg_a;
	assign rd0_en   = ((state_q == ST_IDLE) && item_valid) || (state_q == ST_EXEC);
	assign rd1_en   = (state_q == ST_IDLE) && item_valid;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cur_q.reg_a] <= nv_q;
		end
		if (rd0_en) begin
			rd0_q <= vld_q[rd0_addr] ? mem[rd0_addr] : '0;
		end
		if (rd1_en) begin
			rd1_q <= vld_q[item.reg_c] ? mem[item.reg_c] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[cur_q.reg_a] <= 1'b1;
		end
	end

	assign prod = rd0_q * rd1_q;

	always_comb begin
		ex_wr  = 1'b0;
		ex_dz  = 1'b0;
		ex_div = 1'b0;
		ex_nv  = '0;
		unique case (cur_q.func)
			OP_CMOV: begin
				ex_wr = (rd1_q != '0);
				ex_nv = rd0_q;
			end
			OP_ADD: begin
				ex_wr = 1'b1;
				ex_nv = rd0_q + rd1_q;
			end
			OP_MULT: begin
				ex_wr = 1'b1;
				ex_nv = prod;
			end
			OP_DIV: begin
				ex_dz  = (rd1_q == '0);
				ex_div = (rd1_q != '0);
			end
			OP_NAND: begin
				ex_wr = 1'b1;
				ex_nv = ~(rd0_q & rd1_q);
			end
			OP_LOADV: begin
				ex_wr = 1'b1;
				ex_nv = {{(WORD_W - IMM_W){1'b0}}, cur_q.imm};
			end
			default: begin
				ex_wr = 1'b0;
			end
		endcase
	end

	assign div_req.start    = (state_q == ST_EXEC) && ex_div;
	assign div_req.dividend = rd0_q;
	assign div_req.divisor  = rd1_q;

	assign out_free = !out_valid_q || m_tready;
	assign mem_we   = (state_q == ST_FINISH) && out_free && wr_q;

	always_comb begin
		fin.pad         = '0;
		fin.div_by_zero = dz_q;
		fin.dest_value  = wr_q ? nv_q : rd0_q;
		fin.dest_reg    = cur_q.reg_a;
		fin.wrote       = wr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			wr_q        <= 1'b0;
			dz_q        <= 1'b0;
			nv_q        <= '0;
			out_q       <= '0;
		end else begin
			// output register loads in finish, empties on a taken result
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						cur_q   <= item;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					wr_q    <= ex_wr;
					dz_q    <= ex_dz;
					nv_q    <= ex_nv;
					state_q <= ex_div ? ST_DIV : ST_FINISH;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						wr_q    <= 1'b1;
						nv_q    <= div_rsp.quotient;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_q   <= fin;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_ready = (state_q == ST_IDLE);
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_q;

`ifndef NO_ASSERTIONS
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(out_q.wrote && out_q.div_by_zero))
		else $error("result marks both a write and a zero divisor");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (div_req.divisor != '0))
		else $error("divider started with a zero divisor");

	a_div_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_rsp.busy || div_rsp.done))
		else $error("waiting on an idle divider");

	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> vld_q[$past(cur_q.reg_a)])
		else $error("written register not marked valid");
`endif

endmodule

FILE: hw/rtl/register_file_execute_unit.sv
// top level of the register file execute unit
//
// s_* channel: one request per handshake, s_tuser carries the operation
// selector and s_tdata the 32-bit instruction word. m_* channel: one
// result per request, in request order, from the output register.
// a front end decodes register fields and parks requests in a small
// queue (QUEUE_DEPTH entries), so s_tready stays high while the back
// end works, until the queue fills.
// the back end handles one request at a time: issue (read B and C),
// execute (read A), finish (write back, load output register).
// divide runs through a one-bit-per-cycle divider between execute and
// finish; a zero divisor skips the divider.
// reset clears the queue, the output register and the valid bits of
// the eight registers, which then read as zero; there is no clearing pass.
// when m_tready is low the finished result holds in the output register,
// the back end waits in its finish step and the queue keeps filling.
module register_file_execute_unit #(
	parameter int unsigned QUEUE_DEPTH = rfeu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rfeu_pkg::WORD_W-1:0]   s_tdata,   // instr_word
	input  logic [rfeu_pkg::FUNC_W-1:0]   s_tuser,   // func
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// wrote, dest_reg, dest_value, div_by_zero, zero pad
	output logic [rfeu_pkg::RESULT_W-1:0] m_tdata
);
	import rfeu_pkg::*;

	// decoded request between front and back
	logic     item_valid;
	logic     item_ready;
	item_t    item;

	// divider control
	div_req_t div_req;
	div_rsp_t div_rsp;

	rfeu_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	// iterative divider used by the back end
	rfeu_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// register file, sequencer and output register
	rfeu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.div_req    (div_req),
		.div_rsp    (div_rsp)
	);

endmodule
